// ===== hw/rtl/slif_pkg.sv =====
// ----------------------------------------------------------------------------
// slif_pkg: shared types and constants for the spiking LIF layer
// Sizes, fixed-point formats, operation and register codes, controller
// states, the command/status structs and the saturation helper.
// ----------------------------------------------------------------------------
package slif_pkg;

  // Layer geometry and number format (signed Q3.12 by default)
  localparam int INPUTS     = 32;
  localparam int OUTPUTS    = 32;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 12;

  // Field widths of the channels
  localparam int OP_W       = 2;
  localparam int SPIKE_W    = 32;
  localparam int INDEX_W    = 5;
  localparam int WVAL_W     = 16;
  localparam int TAU_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int ROW_W    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int NRN_W    = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int CNT_W    = (ROW_W > NRN_W) ? ROW_W : NRN_W;
  localparam int ROW_BITS = OUTPUTS * VALUE_BITS;
  localparam int ACC_W    = VALUE_BITS + $clog2(INPUTS + 1);
  localparam int DIFF_W   = ACC_W + 1;
  localparam int PROD_W   = DIFF_W + TAU_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int SAT_W    = SUM_W - TAU_W;

  // Constants
  localparam longint VMAX       = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
  localparam longint ONE_V      = longint'(1) <<< FRAC_BITS;
  localparam int     ROUND_HALF = 1 << (TAU_W - 1);
  localparam logic [TAU_W-1:0] TAU_RST = TAU_W'(1 << (TAU_W - 2));
  localparam logic signed [VALUE_BITS-1:0] THRESH_RST =
    VALUE_BITS'((ONE_V > VMAX) ? VMAX : ONE_V);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LEAK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_STEP   = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2,
    OP_CLEAR  = 2'd3
  } slif_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRD,
    S_WWR,
    S_ROWS,
    S_SETTLE,
    S_LEAK,
    S_FINISH
  } slif_state_t;

  // Controller to datapath
  typedef struct packed {
    logic             cap_item;
    logic             wr_bias;
    logic             clr_mem;
    logic             wt_rd;
    logic             wt_wr;
    logic             row_rd;
    logic [ROW_W-1:0] row_addr;
    logic             acc_init;
    logic             leak_issue;
    logic [NRN_W-1:0] leak_idx;
    logic             out_load;
  } slif_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } slif_sts_t;

  // Clamp to the signed VALUE_BITS range
  function automatic logic signed [VALUE_BITS-1:0] sat_value(
    input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(VMAX);
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      return hi[VALUE_BITS-1:0];
    end else if (x < lo) begin
      return lo[VALUE_BITS-1:0];
    end
    return x[VALUE_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/slif_if.sv =====
// ----------------------------------------------------------------------------
// slif_if: channel interfaces of the spiking LIF layer
// Item, result and configuration channels, each valid/ready with payload.
// ----------------------------------------------------------------------------
interface slif_in_if import slif_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [SPIKE_W-1:0]       in_spikes;
  logic [INDEX_W-1:0]       pre_index;
  logic [INDEX_W-1:0]       post_index;
  logic signed [WVAL_W-1:0] write_value;

  modport source (output valid, operation, in_spikes, pre_index, post_index,
                  write_value, input ready);
  modport sink   (input valid, operation, in_spikes, pre_index, post_index,
                  write_value, output ready);
endinterface

interface slif_out_if import slif_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPIKE_W-1:0] out_spikes;

  modport source (output valid, out_spikes, input ready);
  modport sink   (input valid, out_spikes, output ready);
endinterface

interface slif_cfg_if import slif_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/slif_ram.sv =====
// ----------------------------------------------------------------------------
// slif_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module slif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read the addressed word
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/slif_ctrl.sv =====
// ----------------------------------------------------------------------------
// slif_ctrl: sequencer of the spiking LIF layer
// Decodes accepted items, walks weight rows and then neurons, and hands the
// spike vector to the output register.
// ----------------------------------------------------------------------------
module slif_ctrl import slif_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  slif_op_t  in_op,
  input  slif_sts_t sts,
  output logic      in_ready,
  output slif_cmd_t cmd
);

  slif_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          case (in_op)
            OP_STEP: begin
              cmd.acc_init = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = S_ROWS;
            end
            OP_WEIGHT: state_nxt   = S_WRD;
            OP_BIAS:   cmd.wr_bias = 1'b1;
            OP_CLEAR:  cmd.clr_mem = 1'b1;
            default: ;
          endcase
        end
      end
      // Fetch the weight row, then write it back with one lane replaced
      S_WRD: begin
        cmd.wt_rd = 1'b1;
        state_nxt = S_WWR;
      end
      S_WWR: begin
        cmd.wt_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      // Read one weight row per cycle
      S_ROWS: begin
        cmd.row_rd   = 1'b1;
        cmd.row_addr = ROW_W'(cnt_r);
        if (cnt_r == CNT_W'(INPUTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SETTLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      // Let the last row land in the accumulators
      S_SETTLE: state_nxt = S_LEAK;
      // Issue one neuron per cycle into the membrane pipeline
      S_LEAK: begin
        cmd.leak_issue = 1'b1;
        cmd.leak_idx   = NRN_W'(cnt_r);
        if (cnt_r == CNT_W'(OUTPUTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      // Drain the pipeline, then load the result once the register is free
      S_FINISH: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A row write always follows its row read
  a_wwr_after_wrd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WWR |-> $past(state_r) == S_WRD)
    else $error("row write without preceding row read");

  // The neuron walk starts at neuron zero
  a_leak_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEAK && $past(state_r) == S_SETTLE |-> cnt_r == '0)
    else $error("neuron walk did not start at zero");

  // A result is only released from an empty pipeline
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> $past(state_r) == S_FINISH && !$past(sts.pipe_busy))
    else $error("result loaded before pipeline drained");

endmodule

// ===== hw/rtl/slif_dp.sv =====
// ----------------------------------------------------------------------------
// slif_dp: datapath of the spiking LIF layer
// Holds configuration, biases, membranes, the row-wide weight RAM, the 32
// current accumulators, the three-stage membrane pipeline and the output
// register.
// ----------------------------------------------------------------------------
module slif_dp import slif_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  slif_cmd_t                cmd,
  output slif_sts_t                sts,
  input  logic [SPIKE_W-1:0]       in_spikes,
  input  logic [INDEX_W-1:0]       pre_index,
  input  logic [INDEX_W-1:0]       post_index,
  input  logic signed [WVAL_W-1:0] write_value,
  input  logic                     cfg_wr,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [SPIKE_W-1:0]       out_spikes
);

  // Configuration
  logic [TAU_W-1:0]               leak_r;
  logic signed [VALUE_BITS-1:0]   thresh_r;

  // Captured item
  logic [SPIKE_W-1:0]             spikes_r;
  logic [ROW_W-1:0]               pre_r;
  logic [NRN_W-1:0]               post_r;
  logic                           wt_ok_r;
  logic signed [VALUE_BITS-1:0]   wval_r;
  logic signed [VALUE_BITS-1:0]   wsat;

  // Neuron state
  logic signed [VALUE_BITS-1:0]   bias_r [OUTPUTS];
  logic signed [VALUE_BITS-1:0]   mem_r  [OUTPUTS];
  logic signed [ACC_W-1:0]        acc_r  [OUTPUTS];

  // Weight RAM, one row of OUTPUTS weights per word
  logic                           ram_en;
  logic                           ram_we;
  logic [ROW_W-1:0]               ram_addr;
  logic [ROW_BITS-1:0]            ram_wdata;
  logic [ROW_BITS-1:0]            ram_rdata;
  logic signed [VALUE_BITS-1:0]   wlane [OUTPUTS];
  logic                           acc_pend_r;
  logic [ROW_W-1:0]               acc_row_r;

  // Membrane pipeline
  logic signed [DIFF_W-1:0]       diff;
  logic signed [TAU_W:0]          tau_s;
  logic signed [PROD_W-1:0]       prod;
  logic                           s1_vld_r;
  logic [NRN_W-1:0]               s1_idx_r;
  logic signed [PROD_W-1:0]       s1_prod_r;
  logic signed [ACC_W-1:0]        s1_acc_r;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SAT_W-1:0]        q;
  logic                           s2_vld_r;
  logic [NRN_W-1:0]               s2_idx_r;
  logic signed [VALUE_BITS-1:0]   s2_v_r;
  logic signed [SAT_W-1:0]        over;
  logic                           fire;
  logic signed [VALUE_BITS-1:0]   v_new;
  logic [OUTPUTS-1:0]             fired_r;

  // Output register
  logic                           out_vld_r;
  logic [SPIKE_W-1:0]             out_spk_r;

  assign wsat = sat_value(SAT_W'(write_value));

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r   <= TAU_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_wr) begin
      if (cfg_index == REG_LEAK) begin
        leak_r <= TAU_W'(cfg_data);
      end else if (cfg_index == REG_THRESH) begin
        thresh_r <= sat_value(SAT_W'(signed'(cfg_data)));
      end
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      spikes_r <= in_spikes;
      pre_r    <= ROW_W'(pre_index);
      post_r   <= NRN_W'(post_index);
      wt_ok_r  <= (int'(pre_index) < INPUTS) && (int'(post_index) < OUTPUTS);
      wval_r   <= wsat;
    end
  end

  // Bias store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < OUTPUTS; n++) begin
        bias_r[n] <= '0;
      end
    end else if (cmd.wr_bias && (int'(post_index) < OUTPUTS)) begin
      bias_r[NRN_W'(post_index)] <= wsat;
    end
  end

  // Weight RAM port: row walk or read-modify-write of one lane
  assign ram_en   = cmd.row_rd | cmd.wt_rd | cmd.wt_wr;
  assign ram_we   = cmd.wt_wr & wt_ok_r;
  assign ram_addr = cmd.row_rd ? cmd.row_addr : pre_r;

  always_comb begin
    for (int n = 0; n < OUTPUTS; n++) begin
      wlane[n] = signed'(ram_rdata[n*VALUE_BITS +: VALUE_BITS]);
      ram_wdata[n*VALUE_BITS +: VALUE_BITS] =
        (NRN_W'(n) == post_r) ? wval_r : ram_rdata[n*VALUE_BITS +: VALUE_BITS];
    end
  end

  slif_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (INPUTS)
  ) u_wram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Track which row arrives from the RAM next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_pend_r <= 1'b0;
    end else begin
      acc_pend_r <= cmd.row_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      acc_row_r <= cmd.row_addr;
    end
  end

  // Current accumulators: load bias, then add each spiking row
  always_ff @(posedge clk) begin
    for (int n = 0; n < OUTPUTS; n++) begin
      if (cmd.acc_init) begin
        acc_r[n] <= ACC_W'(bias_r[n]);
      end else if (acc_pend_r && spikes_r[acc_row_r]) begin
        acc_r[n] <= acc_r[n] + ACC_W'(wlane[n]);
      end
    end
  end

  // Stage 1: tau*v + (1-tau)*I rewritten as I*2^16 + tau*(v - I)
  assign tau_s = signed'({1'b0, leak_r});
  assign diff  = DIFF_W'(mem_r[cmd.leak_idx]) - DIFF_W'(acc_r[cmd.leak_idx]);
  assign prod  = tau_s * diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.leak_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.leak_issue) begin
      s1_idx_r  <= cmd.leak_idx;
      s1_prod_r <= prod;
      s1_acc_r  <= acc_r[cmd.leak_idx];
    end
  end

  // Stage 2: add, round to nearest with ties up, saturate
  assign sum = (SUM_W'(s1_acc_r) <<< TAU_W) + SUM_W'(s1_prod_r) + SUM_W'(ROUND_HALF);
  assign q   = SAT_W'(sum >>> TAU_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_idx_r <= s1_idx_r;
      s2_v_r   <= sat_value(q);
    end
  end

  // Stage 3: fire above threshold and subtract it
  assign over  = SAT_W'(s2_v_r) - SAT_W'(thresh_r);
  assign fire  = s2_v_r > thresh_r;
  assign v_new = fire ? sat_value(over) : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < OUTPUTS; n++) begin
        mem_r[n] <= '0;
      end
    end else if (cmd.clr_mem) begin
      for (int n = 0; n < OUTPUTS; n++) begin
        mem_r[n] <= '0;
      end
    end else if (s2_vld_r) begin
      mem_r[s2_idx_r] <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      fired_r <= '0;
    end else if (s2_vld_r) begin
      fired_r[s2_idx_r] <= fire;
    end
  end

  // Output register; holds until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_spk_r <= SPIKE_W'(fired_r);
    end
  end

  assign out_valid  = out_vld_r;
  assign out_spikes = out_spk_r;

  always_comb begin
    sts.pipe_busy = s1_vld_r | s2_vld_r;
    sts.out_free  = !out_vld_r || out_ready;
  end

  // Stage 2 is only filled from stage 1
  a_s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> $past(s1_vld_r))
    else $error("membrane stage 2 valid without stage 1");

  // A new result never overwrites one that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_vld_r || out_ready)
    else $error("result register overwritten");

  // Row additions and neuron issue never overlap
  a_rows_before_leak: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.leak_issue |-> !acc_pend_r && !cmd.row_rd)
    else $error("neuron issued while rows still accumulating");

endmodule

// ===== hw/rtl/spiking_lif_layer_unit.sv =====
// ----------------------------------------------------------------------------
// spiking_lif_layer_unit: fully connected layer of leaky integrate-and-fire
// neurons, one timestep per transaction.
//
// in_if takes operations: timestep (spike vector in), weight write, bias
// write, membrane clear. A timestep returns one out_spikes transaction on
// out_if; every other operation returns nothing. cfg_if writes leak_factor
// (index 0) and spike_threshold (index 1) at any time, ready is always high;
// write it only while the layer is idle.
// A bias write or membrane clear is done on acceptance; a weight write is a
// read-modify-write of a row-wide weight RAM word. A timestep runs from
// acceptance to result as one weight row per cycle through the single RAM
// port, then one neuron per cycle through the shared leak multiplier
// pipeline. One item at a time.
// Reset clears biases and membranes and loads tau 0.25 and threshold 1.0;
// weights hold garbage until written. A stalled receiver leaves the result
// in the output register; the next item is still taken, and a following
// timestep waits at its end until the register is free.
// ----------------------------------------------------------------------------
module spiking_lif_layer_unit import slif_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  slif_in_if.sink     in_if,
  slif_out_if.source  out_if,
  slif_cfg_if.sink    cfg_if
);

  slif_cmd_t cmd;
  slif_sts_t sts;
  logic      in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  // Sequencer
  slif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (slif_op_t'(in_if.operation)),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  slif_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_spikes   (in_if.in_spikes),
    .pre_index   (in_if.pre_index),
    .post_index  (in_if.post_index),
    .write_value (in_if.write_value),
    .cfg_wr      (cfg_if.valid),
    .cfg_index   (cfg_if.index),
    .cfg_data    (cfg_if.data),
    .out_ready   (out_if.ready),
    .out_valid   (out_if.valid),
    .out_spikes  (out_if.out_spikes)
  );

endmodule
